// File: rtl/rtd_resistance_to_temperature_macros.svh
// assertion macros shared by the rtd converter rtl
`ifndef RTD_RESISTANCE_TO_TEMPERATURE_MACROS_SVH
`define RTD_RESISTANCE_TO_TEMPERATURE_MACROS_SVH

// all macros sample on clk and are disabled while rst is high
// condition holds on every edge
`define RTD_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define RTD_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define RTD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/rtd_pkg.sv
// shared constants, calibration rom and helpers for the rtd converter
package rtd_pkg;

  localparam int RES_W       = 16;
  localparam int TEMP_W      = 18;
  localparam int STATUS_W    = 2;
  localparam int CENTI       = 100;
  localparam int BASE_DEGREES = 200;
  localparam int ROM_ENTRIES = 211;
  localparam int ROM_IDX_W   = 8;

  localparam logic [STATUS_W-1:0] STATUS_IN_RANGE = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BELOW    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ABOVE    = 2'd2;

  // pt100 reference resistance in centiohm, 5 degree steps from -200 c
  localparam logic [RES_W-1:0] CALIB_ROM [0:ROM_ENTRIES-1] = '{
    16'd1852, 16'd2068, 16'd2283, 16'd2497, 16'd2710, 16'd2922, 16'd3134, 16'd3344,
    16'd3554, 16'd3764, 16'd3972, 16'd4180, 16'd4388, 16'd4594, 16'd4800, 16'd5006,
    16'd5211, 16'd5415, 16'd5619, 16'd5823, 16'd6026, 16'd6228, 16'd6430, 16'd6631,
    16'd6833, 16'd7033, 16'd7233, 16'd7433, 16'd7633, 16'd7832, 16'd8031, 16'd8229,
    16'd8427, 16'd8625, 16'd8822, 16'd9019, 16'd9216, 16'd9412, 16'd9609, 16'd9804,
    16'd10000, 16'd10195, 16'd10390, 16'd10585, 16'd10779, 16'd10973, 16'd11167,
    16'd11361, 16'd11554, 16'd11747, 16'd11940, 16'd12132, 16'd12324, 16'd12516,
    16'd12708, 16'd12899, 16'd13090, 16'd13280, 16'd13471, 16'd13661, 16'd13851,
    16'd14040, 16'd14229, 16'd14418, 16'd14607, 16'd14795, 16'd14983, 16'd15171,
    16'd15358, 16'd15546, 16'd15733, 16'd15919, 16'd16105, 16'd16291, 16'd16477,
    16'd16663, 16'd16848, 16'd17033, 16'd17217, 16'd17402, 16'd17586, 16'd17769,
    16'd17953, 16'd18136, 16'd18319, 16'd18501, 16'd18684, 16'd18866, 16'd19047,
    16'd19229, 16'd19410, 16'd19591, 16'd19771, 16'd19951, 16'd20131, 16'd20311,
    16'd20490, 16'd20670, 16'd20848, 16'd21027, 16'd21205, 16'd21383, 16'd21561,
    16'd21738, 16'd21915, 16'd22092, 16'd22268, 16'd22445, 16'd22621, 16'd22796,
    16'd22972, 16'd23147, 16'd23321, 16'd23496, 16'd23670, 16'd23844, 16'd24018,
    16'd24191, 16'd24364, 16'd24537, 16'd24709, 16'd24881, 16'd25053, 16'd25225,
    16'd25396, 16'd25567, 16'd25738, 16'd25908, 16'd26078, 16'd26248, 16'd26418,
    16'd26587, 16'd26756, 16'd26925, 16'd27093, 16'd27261, 16'd27429, 16'd27597,
    16'd27764, 16'd27931, 16'd28098, 16'd28264, 16'd28430, 16'd28596, 16'd28762,
    16'd28927, 16'd29092, 16'd29256, 16'd29421, 16'd29585, 16'd29749, 16'd29912,
    16'd30075, 16'd30238, 16'd30401, 16'd30563, 16'd30725, 16'd30887, 16'd31049,
    16'd31210, 16'd31371, 16'd31531, 16'd31692, 16'd31852, 16'd32012, 16'd32171,
    16'd32330, 16'd32489, 16'd32648, 16'd32806, 16'd32964, 16'd33122, 16'd33279,
    16'd33436, 16'd33593, 16'd33750, 16'd33906, 16'd34062, 16'd34218, 16'd34373,
    16'd34528, 16'd34683, 16'd34838, 16'd34992, 16'd35146, 16'd35300, 16'd35453,
    16'd35606, 16'd35759, 16'd35912, 16'd36064, 16'd36216, 16'd36367, 16'd36519,
    16'd36670, 16'd36821, 16'd36971, 16'd37121, 16'd37271, 16'd37421, 16'd37570,
    16'd37719, 16'd37868, 16'd38017, 16'd38165, 16'd38313, 16'd38460, 16'd38608,
    16'd38755, 16'd38902, 16'd39048
  };

  // entries past the calibration data repeat the last value
  function automatic logic [RES_W-1:0] table_entry(input logic [ROM_IDX_W-1:0] idx);
    if (idx < ROM_ENTRIES) begin
      return CALIB_ROM[idx];
    end else begin
      return CALIB_ROM[ROM_ENTRIES-1];
    end
  endfunction

endpackage

// File: rtl/rtd_ram.sv
// generic single-port-write ram with registered read
module rtd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/rtd_div.sv
// restoring divider, one quotient bit per cycle, quotient known to fit Q_W bits
module rtd_div #(
  parameter int DEN_W = 16,
  parameter int Q_W   = 9
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [DEN_W+Q_W-1:0]   num,
  input  logic [DEN_W-1:0]       den,
  output logic                   done,
  output logic [Q_W-1:0]         quot,
  output logic                   rem_nz
);

  localparam int CNT_W = (Q_W > 1) ? $clog2(Q_W) : 1;

  logic [DEN_W-1:0] rem;
  logic [Q_W-1:0]   qn;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt;
  logic             active;

  logic [DEN_W:0]   rem_sh;
  logic             ge;
  logic [DEN_W:0]   rem_sub;

  always_comb begin
    rem_sh  = {rem, qn[Q_W-1]};
    ge      = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(Q_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // numerator high part starts below den, so rem always fits DEN_W bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num[DEN_W+Q_W-1:Q_W];
      qn    <= num[Q_W-1:0];
      den_q <= den;
    end else if (active) begin
      rem <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      qn  <= {qn[Q_W-2:0], ge};
    end
  end

  assign quot   = qn;
  assign rem_nz = |rem;

endmodule

// File: rtl/rtd_resistance_to_temperature.sv
// pt100 resistance to temperature converter, top level
//
//  channel   | handshake       | payload
//  ----------+-----------------+------------------------------------------
//  request   | start / busy    | resistance_centiohm (16b unsigned)
//  result    | done (1 cycle)  | temperature_centideg (18b signed),
//            |                 | range_status (2b)
//
// after reset the table ram is filled from the calibration rom, one entry
//   a cycle, with busy high
// below the table: busy through S_LOW only, above it: through S_LOW and S_HIGH,
//   the result comes the cycle busy drops
// in range: S_LOW, S_HIGH, the probes, S_BOT, S_TOP, S_DIV (an exact hit or a flat
//   segment ends sooner), probes at most ceil(log2(entries-1)); one ram read per cycle
//   sets the search, the divider one quotient bit per cycle
// done is a single-cycle strobe; the receiver cannot stall it

`include "rtd_resistance_to_temperature_macros.svh"

module rtd_resistance_to_temperature #(
  parameter int TABLE_ENTRIES = 211,
  parameter int STEP_DEGREES  = 5
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [rtd_pkg::RES_W-1:0]           resistance_centiohm,
  output logic                                done,
  output logic signed [rtd_pkg::TEMP_W-1:0]   temperature_centideg,
  output logic [rtd_pkg::STATUS_W-1:0]        range_status
);

  import rtd_pkg::*;

  localparam int IDX_W      = $clog2(TABLE_ENTRIES);
  localparam int STEP_CENTI = STEP_DEGREES * CENTI;
  localparam int BASE_CENTI = BASE_DEGREES * CENTI;
  // quotient of the interpolation never exceeds one step in centidegrees
  localparam int Q_W        = $clog2(STEP_CENTI + 1);
  localparam int NUM_W      = RES_W + Q_W;
  localparam int ACC_RAW    = $clog2((TABLE_ENTRIES * STEP_DEGREES + BASE_DEGREES) * CENTI) + 2;
  localparam int ACC_W      = (ACC_RAW > TEMP_W) ? ACC_RAW : TEMP_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [7:0] {
    S_INIT   = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_LOW    = 8'b0000_0100,
    S_HIGH   = 8'b0000_1000,
    S_SEARCH = 8'b0001_0000,
    S_BOT    = 8'b0010_0000,
    S_TOP    = 8'b0100_0000,
    S_DIV    = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  // request and search registers
  logic [RES_W-1:0] res;
  logic [IDX_W-1:0] fill_idx;
  logic [IDX_W-1:0] lo_idx, hi_idx, probe;
  logic [RES_W-1:0] tab_bot;
  logic [RES_W-1:0] diff;

  // table ram ports
  logic [IDX_W-1:0] raddr;
  logic [RES_W-1:0] rdata;

  // bounds after this cycle's probe, and the next probe address
  logic             less, greater;
  logic [IDX_W-1:0] bnd_lo, bnd_hi, bnd_mid;
  logic [IDX_W:0]   bnd_sum;
  logic             bnd_narrow;

  // interpolation
  logic [RES_W-1:0] den;
  logic [NUM_W-1:0] div_num;
  logic             div_start, div_done, div_rem_nz;
  logic [Q_W-1:0]   div_quot;
  logic [IDX_W-1:0] step_idx;
  logic [ACC_W-1:0] step_temp;
  logic [ACC_W-1:0] interp_temp;

  // result staging
  logic                out_valid;
  logic [ACC_W-1:0]    out_temp;
  logic [STATUS_W-1:0] out_status;

  rtd_ram #(
    .WIDTH(RES_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (state == S_INIT),
    .waddr(fill_idx),
    .wdata(table_entry(ROM_IDX_W'(fill_idx))),
    .raddr(raddr),
    .rdata(rdata)
  );

  rtd_div #(
    .DEN_W(RES_W),
    .Q_W  (Q_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (den),
    .done  (div_done),
    .quot  (div_quot),
    .rem_nz(div_rem_nz)
  );

  assign busy = (state != S_IDLE);

  // compare the probed entry; on entry from S_HIGH the bounds are the whole table
  always_comb begin
    less    = res < rdata;
    greater = res > rdata;
    if (state == S_HIGH) begin
      bnd_lo = '0;
      bnd_hi = LAST_IDX;
    end else begin
      bnd_lo = greater ? probe : lo_idx;
      bnd_hi = less ? probe : hi_idx;
    end
    bnd_sum    = {1'b0, bnd_lo} + {1'b0, bnd_hi};
    bnd_mid    = bnd_sum[IDX_W:1];
    bnd_narrow = (bnd_hi - bnd_lo) > IDX_W'(1);
  end

  // step temperature in centidegrees, two's complement in ACC_W bits
  always_comb begin
    step_idx  = (state == S_SEARCH) ? probe : lo_idx;
    step_temp = ACC_W'(step_idx) * ACC_W'(STEP_CENTI) - ACC_W'(BASE_CENTI);
  end

  assign den     = rdata - tab_bot;
  assign div_num = NUM_W'(diff) * NUM_W'(STEP_CENTI);

  // base + q, then truncation toward zero bumps a negative result with a remainder
  always_comb begin
    interp_temp = step_temp + ACC_W'(div_quot);
    if (interp_temp[ACC_W-1] && div_rem_nz) begin
      interp_temp = interp_temp + ACC_W'(1);
    end
  end

  always_comb begin
    state_next = state;
    raddr      = '0;
    div_start  = 1'b0;
    out_valid  = 1'b0;
    out_temp   = '0;
    out_status = STATUS_IN_RANGE;
    unique case (state)
      S_INIT: begin
        if (fill_idx == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        raddr = '0;
        if (start) begin
          state_next = S_LOW;
        end
      end
      S_LOW: begin
        if (less) begin
          out_valid  = 1'b1;
          out_status = STATUS_BELOW;
          state_next = S_IDLE;
        end else begin
          raddr      = LAST_IDX;
          state_next = S_HIGH;
        end
      end
      S_HIGH, S_SEARCH: begin
        if (state == S_HIGH && greater) begin
          out_valid  = 1'b1;
          out_status = STATUS_ABOVE;
          state_next = S_IDLE;
        end else if (state == S_SEARCH && !less && !greater) begin
          // exact hit on a probed entry
          out_valid  = 1'b1;
          out_temp   = step_temp;
          state_next = S_IDLE;
        end else if (bnd_narrow) begin
          raddr      = bnd_mid;
          state_next = S_SEARCH;
        end else begin
          raddr      = bnd_lo;
          state_next = S_BOT;
        end
      end
      S_BOT: begin
        raddr      = hi_idx;
        state_next = S_TOP;
      end
      S_TOP: begin
        if (den == '0) begin
          // flat segment
          out_valid  = 1'b1;
          out_temp   = step_temp;
          state_next = S_IDLE;
        end else begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          out_valid  = 1'b1;
          out_temp   = interp_temp;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      fill_idx <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= out_valid;
      if (state == S_INIT) begin
        fill_idx <= fill_idx + IDX_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      res <= resistance_centiohm;
    end
    if (state == S_HIGH || state == S_SEARCH) begin
      lo_idx <= bnd_lo;
      hi_idx <= bnd_hi;
      probe  <= bnd_mid;
    end
    if (state == S_BOT) begin
      tab_bot <= rdata;
      diff    <= res - rdata;
    end
    if (out_valid) begin
      temperature_centideg <= out_temp[TEMP_W-1:0];
      range_status         <= out_status;
    end
  end

  `RTD_ASSERT_IMPLIES(a_out_of_range_zero,
    done && (range_status != STATUS_IN_RANGE), temperature_centideg == '0,
    "out-of-range result carries a temperature")
  `RTD_ASSERT_NEXT(a_request_busy, start && !busy, busy,
    "accepted request did not raise busy")
  `RTD_ASSERT_IMPLIES(a_search_span, state == S_SEARCH, (hi_idx - lo_idx) > IDX_W'(1),
    "search running on a bracket that is already closed")
  `RTD_ASSERT_IMPLIES(a_div_owner, div_done, state == S_DIV,
    "divider finished outside the divide state")

endmodule
